// File: hw/rtl/ptt_pkg.sv
// Shared constants, codes and control/status types of the periodic timer table.
package ptt_pkg;

	localparam int MAX_TIMERS_DEF = 16;

	localparam int CMD_W     = 3;
	localparam int IDX_FW    = 5;
	localparam int ID_W      = 32;
	localparam int US_W      = 32;
	localparam int MS_W      = 23;
	localparam int TIME_W    = 32;
	localparam int KIND_W    = 2;
	localparam int STAT_W    = 2;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 64;

	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESET   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CONTROL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd4;

	localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ACK    = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FAIL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NA   = 2'd2;

	localparam logic [MS_W-1:0] NOTHING_PENDING_MS = 23'd1000;

	// us -> ms: floor(x / 1000) == (x * 0x10624DD3) >> 38 for every 32-bit x
	localparam int              DIV_MUL_W = 29;
	localparam logic [28:0]     DIV_MUL   = 29'd274877907;
	localparam int              DIV_SHIFT = 38;
	localparam int              PROD_W    = US_W + DIV_MUL_W;

	typedef struct packed {
		logic accept;
		logic divide;
		logic scan_start;
		logic scan_run;
		logic ack;
		logic report;
	} ptt_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic scan_done;
		logic out_free;
	} ptt_stat_t;

endpackage

// File: hw/rtl/ptt_ctrl.sv
// Sequencing state machine of the periodic timer table.
module ptt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  ptt_pkg::ptt_stat_t stat,
	output ptt_pkg::ptt_cmd_t  cmd
);
	import ptt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ACK,
		ST_SCAN,
		ST_REPORT
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && ready_q) begin
						state_q <= ST_DISPATCH;
						ready_q <= 1'b0;
					end
				end
				ST_DISPATCH: begin
					state_q <= stat.is_tick ? ST_SCAN : ST_ACK;
				end
				ST_ACK: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (stat.scan_done)
						state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign s_tready = ready_q;

	always_comb begin
		cmd.accept     = (state_q == ST_IDLE) && s_tvalid && ready_q;
		cmd.divide     = (state_q == ST_DISPATCH);
		cmd.scan_start = (state_q == ST_DISPATCH) && stat.is_tick;
		cmd.scan_run   = (state_q == ST_SCAN);
		cmd.ack        = (state_q == ST_ACK) && stat.out_free;
		cmd.report     = (state_q == ST_REPORT) && stat.out_free;
	end

endmodule

// File: hw/rtl/ptt_datapath.sv
// Timer table storage, slot scan, period conversion and output register.
module ptt_datapath #(
	parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ptt_pkg::ptt_cmd_t               cmd,
	output ptt_pkg::ptt_stat_t              stat,
	input  logic [ptt_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [ptt_pkg::CMD_W-1:0]       s_tuser,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [ptt_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [ptt_pkg::KIND_W-1:0]      m_tuser,
	output logic                            m_tlast
);
	import ptt_pkg::*;

	localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CNT_W = $clog2(MAX_TIMERS + 1);

	// latched transaction
	logic [CMD_W-1:0]  cmd_q;
	logic [IDX_FW-1:0] idx_q;
	logic              en_q;
	logic [US_W-1:0]   period_us_q;
	logic [ID_W-1:0]   uid_q;
	logic [MS_W-1:0]   period_ms_q;
	logic [PROD_W-1:0] prod;

	// table state
	logic [TIME_W-1:0]     time_now_q;
	logic [CNT_W-1:0]      slots_used_q;
	logic [MAX_TIMERS-1:0] live_q;
	logic [MAX_TIMERS-1:0] enabled_q;

	logic [MS_W-1:0]   period_mem [MAX_TIMERS];
	logic [TIME_W-1:0] last_mem   [MAX_TIMERS];
	logic [ID_W-1:0]   uid_mem    [MAX_TIMERS];
	logic [MS_W-1:0]   rd_period_q;
	logic [TIME_W-1:0] rd_last_q;
	logic [ID_W-1:0]   rd_uid_q;

	// scan
	logic [CNT_W-1:0] scan_i_q;
	logic             ev_valid_q;
	logic [IDX_W-1:0] ev_i_q;
	logic             have_min_q;
	logic [MS_W-1:0]  min_q;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [ID_W-1:0]   out_id_q;
	logic [IDX_FW-1:0] out_slot_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [MS_W-1:0]   out_sleep_q;
	logic              out_last_q;

	logic              out_free;
	logic [IDX_W-1:0]  idx_w;
	logic [IDX_W-1:0]  new_slot;
	logic              idx_in_range;
	logic              exists;
	logic              table_full;
	logic              ev_active;
	logic [TIME_W-1:0] elapsed;
	logic              expire;
	logic [MS_W-1:0]   left;
	logic              stall;
	logic              step;
	logic              more;
	logic              emit_exp;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic              wr_period_en;
	logic              wr_last_en;
	logic              wr_uid_en;
	logic [IDX_FW-1:0] ack_slot;
	logic [STAT_W-1:0] ack_stat;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q       <= s_tuser;
			idx_q       <= s_tdata[4:0];
			en_q        <= s_tdata[5];
			period_us_q <= s_tdata[37:6];
			uid_q       <= s_tdata[69:38];
		end
		if (cmd.divide)
			period_ms_q <= prod[DIV_SHIFT +: MS_W];
	end

	assign prod = PROD_W'(period_us_q) * PROD_W'(DIV_MUL);

	assign out_free     = !out_valid_q || m_tready;
	assign idx_w        = IDX_W'(idx_q);
	assign new_slot     = IDX_W'(slots_used_q);
	assign idx_in_range = 32'(idx_q) < 32'(slots_used_q);
	assign exists       = idx_in_range && live_q[idx_w];
	assign table_full   = 32'(slots_used_q) >= 32'(MAX_TIMERS);

	assign ev_active = ev_valid_q && live_q[ev_i_q] && enabled_q[ev_i_q];
	assign elapsed   = time_now_q - rd_last_q;
	assign expire    = elapsed >= TIME_W'(rd_period_q);
	assign left      = rd_period_q - elapsed[MS_W-1:0];
	assign stall     = cmd.scan_run && ev_active && expire && !out_free;
	assign step      = cmd.scan_run && !stall;
	assign more      = scan_i_q < slots_used_q;
	assign emit_exp  = step && ev_active && expire;
	assign rd_en     = step && more;
	assign rd_addr   = IDX_W'(scan_i_q);

	always_comb begin
		wr_addr      = ev_i_q;
		wr_period_en = 1'b0;
		wr_last_en   = 1'b0;
		wr_uid_en    = 1'b0;
		priority if (cmd.ack && cmd_q == CMD_CREATE && !table_full) begin
			wr_addr      = new_slot;
			wr_period_en = 1'b1;
			wr_last_en   = 1'b1;
			wr_uid_en    = 1'b1;
		end else if (cmd.ack && cmd_q == CMD_RESET && exists) begin
			wr_addr      = idx_w;
			wr_period_en = 1'b1;
			wr_last_en   = 1'b1;
		end else begin
			wr_last_en = emit_exp;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_period_en)
			period_mem[wr_addr] <= period_ms_q;
		if (wr_last_en)
			last_mem[wr_addr] <= time_now_q;
		if (wr_uid_en)
			uid_mem[wr_addr] <= uid_q;
		if (rd_en) begin
			rd_period_q <= period_mem[rd_addr];
			rd_last_q   <= last_mem[rd_addr];
			rd_uid_q    <= uid_mem[rd_addr];
		end
	end

	always_comb begin
		ack_slot = idx_q;
		ack_stat = STAT_OK;
		unique case (cmd_q)
			CMD_CREATE: begin
				ack_slot = table_full ? '0 : IDX_FW'(slots_used_q);
				ack_stat = table_full ? STAT_FAIL : STAT_OK;
			end
			CMD_RESET, CMD_DELETE: begin
				ack_stat = STAT_OK;
			end
			CMD_CONTROL: begin
				ack_stat = exists ? STAT_OK : STAT_FAIL;
			end
			default: begin
				ack_slot = '0;
				ack_stat = STAT_FAIL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_now_q   <= '0;
			slots_used_q <= '0;
			live_q       <= '0;
			enabled_q    <= '0;
		end else begin
			if (cmd.accept && s_tuser == CMD_TICK)
				time_now_q <= time_now_q + 1'b1;
			if (cmd.ack) begin
				unique case (cmd_q)
					CMD_CREATE: begin
						if (!table_full) begin
							slots_used_q        <= slots_used_q + 1'b1;
							live_q[new_slot]    <= 1'b1;
							enabled_q[new_slot] <= 1'b1;
						end
					end
					CMD_RESET, CMD_CONTROL: begin
						if (exists)
							enabled_q[idx_w] <= en_q;
					end
					CMD_DELETE: begin
						if (idx_in_range)
							live_q[idx_w] <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_i_q   <= '0;
			ev_valid_q <= 1'b0;
			ev_i_q     <= '0;
			have_min_q <= 1'b0;
			min_q      <= '0;
		end else if (cmd.scan_start) begin
			scan_i_q   <= '0;
			ev_valid_q <= 1'b0;
			have_min_q <= 1'b0;
		end else if (step) begin
			if (ev_active && !expire && (!have_min_q || left < min_q)) begin
				min_q      <= left;
				have_min_q <= 1'b1;
			end
			ev_valid_q <= more;
			if (more) begin
				ev_i_q   <= rd_addr;
				scan_i_q <= scan_i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_ACK;
			out_id_q    <= '0;
			out_slot_q  <= '0;
			out_stat_q  <= STAT_OK;
			out_sleep_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			priority if (cmd.ack) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= KIND_ACK;
				out_id_q    <= '0;
				out_slot_q  <= ack_slot;
				out_stat_q  <= ack_stat;
				out_sleep_q <= '0;
				out_last_q  <= 1'b1;
			end else if (cmd.report) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= KIND_REPORT;
				out_id_q    <= '0;
				out_slot_q  <= '0;
				out_stat_q  <= STAT_NA;
				out_sleep_q <= have_min_q ? min_q : NOTHING_PENDING_MS;
				out_last_q  <= 1'b1;
			end else if (emit_exp) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= KIND_EXPIRY;
				out_id_q    <= rd_uid_q;
				out_slot_q  <= IDX_FW'(ev_i_q);
				out_stat_q  <= STAT_NA;
				out_sleep_q <= '0;
				out_last_q  <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q && !m_tready;
			end
		end
	end

	assign stat.is_tick   = (cmd_q == CMD_TICK);
	assign stat.scan_done = !ev_valid_q && !more;
	assign stat.out_free  = out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_sleep_q, out_stat_q, out_slot_q, out_id_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// File: hw/rtl/periodic_timer_table.sv
// Periodic timer table: millisecond-tick driven table of periodic timers.
// Sequence: accept, dispatch with period conversion, then an acknowledge, or for a tick a slot scan and a report.
// Throughput: one transaction at a time; the next is accepted once the acknowledge or report is registered.
// Output stalls hold the ack and report; a tick reads one slot per cycle unless an expiry waits on a busy output.
// Reset: time count, slot count, live/enable bits and control clear at once;
// table entries are written at create before they are ever read.
module periodic_timer_table #(
	parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// timer_index[4:0], enable[5], period_us[37:6], user_id[69:38]
	input  logic [ptt_pkg::S_TDATA_W-1:0] s_tdata,
	// command[2:0]
	input  logic [ptt_pkg::CMD_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// expired_id[31:0], slot[36:32], status[38:37], sleep_ms[61:39]
	output logic [ptt_pkg::M_TDATA_W-1:0] m_tdata,
	// kind[1:0]
	output logic [ptt_pkg::KIND_W-1:0]    m_tuser,
	output logic                          m_tlast
);
	import ptt_pkg::*;

	ptt_cmd_t  ctl_cmd;
	ptt_stat_t dp_stat;

	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (dp_stat),
		.cmd      (ctl_cmd)
	);

	ptt_datapath #(
		.MAX_TIMERS (MAX_TIMERS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ctl_cmd),
		.stat     (dp_stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("transaction accepted while previous one in progress");

	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.scan_run |-> !s_tready)
		else $error("input ready during slot scan");

	a_report_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_REPORT |-> m_tlast)
		else $error("deadline report without tlast");

	a_expiry_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_EXPIRY |-> !m_tlast)
		else $error("expiry marked as last");
`endif

endmodule

// File: verif/tb_periodic_timer_table.sv
// Self-checking testbench of the periodic timer table: directed rows, random commands, stalls.
`timescale 1ns / 100ps

module tb_periodic_timer_table;
	import ptt_pkg::*;

	localparam int  MAX_SLOTS      = MAX_TIMERS_DEF;
	localparam int  ITEMS_PER_MIX  = 85;
	localparam int  PRESSURE_ITEMS = 40;
	localparam int  HOLD_CYCLES    = 400;
	localparam int  DRAIN_CYCLES   = 40;
	localparam int  CYCLE_LIMIT    = 400000;
	localparam int  N_ROWS         = 26;

	localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   expired_id;
		logic [IDX_FW-1:0] slot;
		logic [STAT_W-1:0] status;
		logic [MS_W-1:0]   sleep_ms;
		logic              last;
	} timer_result_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_FW-1:0] idx;
		logic              en;
		logic [US_W-1:0]   period_us;
		logic [ID_W-1:0]   user_id;
		logic              typed;
		logic [KIND_W-1:0] kind;
		logic [IDX_FW-1:0] slot;
		logic [STAT_W-1:0] status;
		logic [MS_W-1:0]   sleep_ms;
	} cmd_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;

	// timer table mirror
	logic [TIME_W-1:0]     tbl_time;
	int                    tbl_used;
	logic                  tbl_live [MAX_SLOTS];
	logic                  tbl_en [MAX_SLOTS];
	logic [MS_W-1:0]       tbl_period [MAX_SLOTS];
	logic [TIME_W-1:0]     tbl_last [MAX_SLOTS];
	logic [ID_W-1:0]       tbl_uid [MAX_SLOTS];

	timer_result_t         fresh_results [$];
	timer_result_t         due_results [$];
	cmd_row_t              cmd_rows [0:N_ROWS-1];

	int                    sender_idle_pct;
	int                    stall_pct;
	int                    hold_req;
	int                    hold_done;
	int                    n_fail;
	int                    n_sent;
	int                    n_checked;
	int                    n_expiry;
	int                    n_refused;
	int                    max_burst;
	int                    cycles;

	periodic_timer_table u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("periodic_timer_table: mismatch");
			$finish;
		end
	end

	initial begin
		m_tready  <= 1'b0;
		hold_done <= 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done <= hold_done + 1;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		timer_result_t want;
		int            bad;
		bad = 0;
		if (arst_n && m_tvalid && m_tready) begin
			n_checked <= n_checked + 1;
			if (due_results.size() == 0) begin
				$error("unexpected transaction: kind %0d tdata %h", m_tuser, m_tdata);
				bad = bad + 1;
			end else begin
				want = due_results.pop_front();
				if (m_tuser !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_tuser);
					bad = bad + 1;
				end
				if (m_tdata[31:0] !== want.expired_id) begin
					$error("expired_id: expected %h, got %h", want.expired_id, m_tdata[31:0]);
					bad = bad + 1;
				end
				if (m_tdata[36:32] !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, m_tdata[36:32]);
					bad = bad + 1;
				end
				if (m_tdata[38:37] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tdata[38:37]);
					bad = bad + 1;
				end
				if (m_tdata[61:39] !== want.sleep_ms) begin
					$error("sleep_ms: expected %0d, got %0d", want.sleep_ms, m_tdata[61:39]);
					bad = bad + 1;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					bad = bad + 1;
				end
				if (want.kind == KIND_EXPIRY)
					n_expiry <= n_expiry + 1;
			end
			if (bad != 0)
				n_fail <= n_fail + bad;
		end
	end

	task automatic advance_table(input logic [CMD_W-1:0] cmd, input logic [IDX_FW-1:0] idx,
			input logic en, input logic [US_W-1:0] period_us, input logic [ID_W-1:0] user_id);
		logic [MS_W-1:0]   period_ms;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] left;
		logic [MS_W-1:0]   least;
		bit                pending;
		bit                exists;
		timer_result_t     r;
		begin
			period_ms = MS_W'(period_us / 32'd1000);
			exists    = (idx < tbl_used) && tbl_live[idx[3:0]];
			fresh_results.delete();
			r = '0;
			r.kind   = KIND_ACK;
			r.slot   = idx;
			r.status = STAT_OK;
			r.last   = 1'b1;
			case (cmd)
				CMD_TICK: begin
					tbl_time = tbl_time + 1'b1;
					pending  = 1'b0;
					least    = '0;
					for (int i = 0; i < tbl_used; i++) begin
						if (tbl_live[i] && tbl_en[i]) begin
							elapsed = tbl_time - tbl_last[i];
							if (elapsed >= TIME_W'(tbl_period[i])) begin
								fresh_results.push_back('{KIND_EXPIRY, tbl_uid[i],
									IDX_FW'(i), STAT_NA, MS_W'(0), 1'b0});
								tbl_last[i] = tbl_time;
							end else begin
								left = TIME_W'(tbl_period[i]) - elapsed;
								if (!pending || MS_W'(left) < least) begin
									least   = MS_W'(left);
									pending = 1'b1;
								end
							end
						end
					end
					if (fresh_results.size() > max_burst)
						max_burst = fresh_results.size();
					r.kind     = KIND_REPORT;
					r.slot     = '0;
					r.status   = STAT_NA;
					r.sleep_ms = pending ? least : NOTHING_PENDING_MS;
				end
				CMD_CREATE: begin
					if (tbl_used >= MAX_SLOTS) begin
						r.slot    = '0;
						r.status  = STAT_FAIL;
						n_refused = n_refused + 1;
					end else begin
						tbl_live[tbl_used]   = 1'b1;
						tbl_en[tbl_used]     = 1'b1;
						tbl_period[tbl_used] = period_ms;
						tbl_uid[tbl_used]    = user_id;
						tbl_last[tbl_used]   = tbl_time;
						r.slot   = IDX_FW'(tbl_used);
						tbl_used = tbl_used + 1;
					end
				end
				CMD_RESET: begin
					if (exists) begin
						tbl_en[idx[3:0]]     = en;
						tbl_period[idx[3:0]] = period_ms;
						tbl_last[idx[3:0]]   = tbl_time;
					end
				end
				CMD_CONTROL: begin
					if (exists)
						tbl_en[idx[3:0]] = en;
					else
						r.status = STAT_FAIL;
				end
				CMD_DELETE: begin
					if (idx < tbl_used)
						tbl_live[idx[3:0]] = 1'b0;
				end
				default: begin
					r.slot   = '0;
					r.status = STAT_FAIL;
				end
			endcase
			fresh_results.push_back(r);
		end
	endtask

	// typed rows carry a single hand-written acknowledge or report
	task automatic issue_command(input cmd_row_t row);
		timer_result_t r;
		begin
			while ($urandom_range(99) < sender_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tuser  <= row.cmd;
			s_tdata  <= {2'b00, row.user_id, row.period_us, row.en, row.idx};
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			advance_table(row.cmd, row.idx, row.en, row.period_us, row.user_id);
			n_sent = n_sent + 1;
			if (row.typed) begin
				r = {row.kind, ID_W'(0), row.slot, row.status, row.sleep_ms, 1'b1};
				due_results.push_back(r);
			end else begin
				foreach (fresh_results[i])
					due_results.push_back(fresh_results[i]);
			end
		end
	endtask

	task automatic offer_random_command();
		cmd_row_t row;
		int       pick;
		begin
			row  = '0;
			pick = $urandom_range(99);
			if (pick < 45 || pick >= 88)
				row.cmd = CMD_TICK;
			else if (pick < 53)
				row.cmd = CMD_CREATE;
			else if (pick < 65)
				row.cmd = CMD_RESET;
			else if (pick < 80)
				row.cmd = CMD_CONTROL;
			else if (pick < 84)
				row.cmd = CMD_DELETE;
			else
				row.cmd = CMD_W'($urandom_range(CMD_SPARE7, CMD_SPARE5));
			if (tbl_used > 0 && $urandom_range(3) != 0)
				row.idx = IDX_FW'($urandom_range(tbl_used - 1));
			else
				row.idx = IDX_FW'($urandom_range(31));
			row.en = ($urandom_range(9) < 8);
			if ($urandom_range(99) < 15)
				row.period_us = $urandom();
			else
				row.period_us = $urandom_range(20999);
			row.user_id = $urandom();
			issue_command(row);
		end
	endtask

	initial begin
		int       mix_idle [4];
		int       mix_stall [4];
		cmd_row_t row;

		mix_idle  = '{0, 67, 0, 8};
		mix_stall = '{0, 0, 67, 8};
		cmd_rows = '{
			'{CMD_TICK,    5'd0,  1'b0, 32'd0,        32'd0,        1'b1,
				KIND_REPORT, 5'd0,  STAT_NA,   NOTHING_PENDING_MS},
			'{CMD_CONTROL, 5'd0,  1'b1, 32'd0,        32'd0,        1'b1,
				KIND_ACK,    5'd0,  STAT_FAIL, 23'd0},
			'{CMD_RESET,   5'd31, 1'b1, 32'hFFFFFFFF, 32'd0,        1'b1,
				KIND_ACK,    5'd31, STAT_OK,   23'd0},
			'{CMD_DELETE,  5'd31, 1'b0, 32'd0,        32'd0,        1'b1,
				KIND_ACK,    5'd31, STAT_OK,   23'd0},
			'{CMD_SPARE5,  5'd31, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
				KIND_ACK,    5'd0,  STAT_FAIL, 23'd0},
			'{CMD_SPARE6,  5'd7,  1'b0, 32'd0,        32'd0,        1'b1,
				KIND_ACK,    5'd0,  STAT_FAIL, 23'd0},
			'{CMD_SPARE7,  5'd0,  1'b0, 32'd0,        32'd0,        1'b1,
				KIND_ACK,    5'd0,  STAT_FAIL, 23'd0},
			'{CMD_CREATE,  5'd0,  1'b0, 32'd0,        32'hFFFFFFFF, 1'b1,
				KIND_ACK,    5'd0,  STAT_OK,   23'd0},
			'{CMD_CREATE,  5'd0,  1'b0, 32'hFFFFFFFF, 32'd0,        1'b1,
				KIND_ACK,    5'd1,  STAT_OK,   23'd0},
			'{CMD_CREATE,  5'd0,  1'b0, 32'd999,      32'h00000001, 1'b1,
				KIND_ACK,    5'd2,  STAT_OK,   23'd0},
			'{CMD_CREATE,  5'd0,  1'b0, 32'd3000,     32'hA5A55A5A, 1'b1,
				KIND_ACK,    5'd3,  STAT_OK,   23'd0},
			'{CMD_TICK,    5'd0,  1'b0, 32'd0,        32'd0,        1'b0,
				KIND_REPORT, 5'd0,  STAT_NA,   23'd0},
			'{CMD_CONTROL, 5'd2,  1'b0, 32'd0,        32'd0,        1'b1,
				KIND_ACK,    5'd2,  STAT_OK,   23'd0},
			'{CMD_TICK,    5'd0,  1'b0, 32'd0,        32'd0,        1'b0,
				KIND_REPORT, 5'd0,  STAT_NA,   23'd0},
			'{CMD_TICK,    5'd0,  1'b0, 32'd0,        32'd0,        1'b0,
				KIND_REPORT, 5'd0,  STAT_NA,   23'd0},
			'{CMD_RESET,   5'd1,  1'b1, 32'd1000,     32'd0,        1'b1,
				KIND_ACK,    5'd1,  STAT_OK,   23'd0},
			'{CMD_TICK,    5'd0,  1'b0, 32'd0,        32'd0,        1'b0,
				KIND_REPORT, 5'd0,  STAT_NA,   23'd0},
			'{CMD_DELETE,  5'd0,  1'b0, 32'd0,        32'd0,        1'b1,
				KIND_ACK,    5'd0,  STAT_OK,   23'd0},
			'{CMD_TICK,    5'd0,  1'b0, 32'd0,        32'd0,        1'b0,
				KIND_REPORT, 5'd0,  STAT_NA,   23'd0},
			'{CMD_CONTROL, 5'd0,  1'b1, 32'd0,        32'd0,        1'b1,
				KIND_ACK,    5'd0,  STAT_FAIL, 23'd0},
			'{CMD_RESET,   5'd3,  1'b0, 32'd0,        32'd0,        1'b1,
				KIND_ACK,    5'd3,  STAT_OK,   23'd0},
			'{CMD_CONTROL, 5'd15, 1'b1, 32'd0,        32'd0,        1'b1,
				KIND_ACK,    5'd15, STAT_FAIL, 23'd0},
			'{CMD_CONTROL, 5'd31, 1'b1, 32'd0,        32'd0,        1'b1,
				KIND_ACK,    5'd31, STAT_FAIL, 23'd0},
			'{CMD_RESET,   5'd0,  1'b1, 32'd5000,     32'd0,        1'b1,
				KIND_ACK,    5'd0,  STAT_OK,   23'd0},
			'{CMD_TICK,    5'd0,  1'b0, 32'd0,        32'd0,        1'b0,
				KIND_REPORT, 5'd0,  STAT_NA,   23'd0},
			'{CMD_TICK,    5'd0,  1'b0, 32'd0,        32'd0,        1'b0,
				KIND_REPORT, 5'd0,  STAT_NA,   23'd0}
		};

		arst_n          <= 1'b0;
		s_tvalid        <= 1'b0;
		s_tdata         <= '0;
		s_tuser         <= CMD_TICK;
		stall_pct       <= 0;
		hold_req        <= 0;
		cycles          <= 0;
		n_fail          <= 0;
		n_checked       <= 0;
		n_expiry        <= 0;
		sender_idle_pct = 0;
		n_sent          = 0;
		n_refused       = 0;
		max_burst       = 0;
		tbl_time        = '0;
		tbl_used        = 0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			tbl_live[i]   = 1'b0;
			tbl_en[i]     = 1'b0;
			tbl_period[i] = '0;
			tbl_last[i]   = '0;
			tbl_uid[i]    = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++)
			issue_command(cmd_rows[i]);

		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = mix_idle[p];
			stall_pct       <= mix_stall[p];
			repeat (ITEMS_PER_MIX) offer_random_command();
		end

		// long output hold-off while commands keep coming
		sender_idle_pct = 0;
		stall_pct       <= 0;
		hold_req        <= hold_req + 1;
		repeat (PRESSURE_ITEMS) offer_random_command();

		// fill the table with zero-period timers, overflow it, then tick
		row = '0;
		while (tbl_used < MAX_SLOTS) begin
			row.cmd       = CMD_CREATE;
			row.period_us = $urandom_range(999);
			row.user_id   = $urandom();
			issue_command(row);
		end
		row.cmd = CMD_CREATE;
		issue_command(row);
		row.cmd = CMD_TICK;
		repeat (4) issue_command(row);
		s_tvalid <= 1'b0;

		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands, %0d transactions checked, %0d expiries, largest tick burst %0d",
			n_sent, n_checked, n_expiry, max_burst);
		$display("table filled to %0d slots, %0d creates refused on a full table",
			tbl_used, n_refused);
		if (n_fail == 0)
			$display("periodic_timer_table: match");
		else
			$display("periodic_timer_table: mismatch");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ctrl.sv
hw/rtl/ptt_datapath.sv
hw/rtl/periodic_timer_table.sv
verif/tb_periodic_timer_table.sv
